// ----- hdl/ipv4_header_checksum_insert_macros.svh -----
// Assertion macros shared by the checksum insertion block.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef IPV4_HEADER_CHECKSUM_INSERT_MACROS_SVH
`define IPV4_HEADER_CHECKSUM_INSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define IHC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define IHC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define IHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ihc_pkg.sv -----
// Types and constants for the IPv4 header checksum insertion block.
// No dependencies.
package ihc_pkg;

    localparam int HL_W          = 6;   // width of IHL * 4
    localparam int IHL_SHIFT     = 2;
    localparam int MIN_HDR_BYTES = 20;
    localparam int CK_HI_POS     = 10;
    localparam int CK_LO_POS     = 11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic        dropped;
        logic [31:0] drop_total;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_FIRST,
        ST_HEADER,
        ST_PAYLOAD,
        ST_DISCARD,
        ST_FLUSH_RD,
        ST_FLUSH_WR
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start_pkt;    // byte 0 accepted
        logic store_hdr;    // header byte 1..n accepted
        logic flush_start;  // header complete, rewind read pointer
        logic emit_byte;    // load payload byte into output register
        logic emit_drop;    // load drop report into output register
        logic emit_hdr;     // load buffered header byte into output register
        logic out_last;     // last flag for emit_byte / emit_hdr
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hl_bad;       // header length of incoming byte 0 out of range
        logic hdr_done;     // byte being stored completes the header
        logic flush_last;   // header byte being emitted is the last one
        logic out_free;     // output register can take a transfer this cycle
    } t_sts;

endpackage

// ----- hdl/ipv4_header_checksum_insert.sv -----
// Path: a payload byte is loaded into the output register by its transfer; after the last
// header byte is taken, each header byte is read from the buffer, then loaded into the output.
// Throughput: payload and header collection take one byte per cycle while the output register
// is free; the header flush holds the input while it reads and loads each header byte.
// Reset: synchronous active-low i_rst_n clears sequencer, counters and the output valid;
// the header buffer is not cleared, since every entry is written before it is read.
module ipv4_header_checksum_insert import ihc_pkg::*; #(
    parameter int MAX_HEADER_BYTES = 60
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    ihc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_eop   (i_in_item.end_of_packet),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    ihc_dpath #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    assign o_in_stall = !in_ready;

endmodule

// ----- hdl/ihc_ctrl.sv -----
// Packet sequencer for the checksum insertion block.
// Depends on ihc_pkg and the block's assertion macros.
`include "ipv4_header_checksum_insert_macros.svh"

module ihc_ctrl import ihc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_eop,
    input  t_sts     i_sts,
    output t_cmd     o_cmd,
    output logic     o_in_ready
);

    t_state r_state, n_state;
    logic   r_eop, n_eop;   // end flag seen on the last header byte
    logic   accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FIRST;
            r_eop   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eop   <= n_eop;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_eop   = r_eop;
        case (r_state)
            ST_FIRST: begin
                if (accept) begin
                    if (i_in_eop)          n_state = ST_FIRST;
                    else if (i_sts.hl_bad) n_state = ST_DISCARD;
                    else                   n_state = ST_HEADER;
                end
            end
            ST_HEADER: begin
                if (accept) begin
                    if (i_sts.hdr_done) begin
                        n_state = ST_FLUSH_RD;
                        n_eop   = i_in_eop;
                    end else if (i_in_eop) begin
                        n_state = ST_FIRST;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (accept && i_in_eop) n_state = ST_FIRST;
            end
            ST_DISCARD: begin
                if (accept && i_in_eop) n_state = ST_FIRST;
            end
            ST_FLUSH_RD: begin
                n_state = ST_FLUSH_WR;
            end
            ST_FLUSH_WR: begin
                if (i_sts.out_free) begin
                    if (!i_sts.flush_last) n_state = ST_FLUSH_RD;
                    else if (r_eop)        n_state = ST_FIRST;
                    else                   n_state = ST_PAYLOAD;
                end
            end
            default: n_state = ST_FIRST;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_FIRST: begin
                o_in_ready = i_sts.out_free;
                if (accept) begin
                    o_cmd.start_pkt = 1'b1;
                    o_cmd.emit_drop = i_in_eop;
                end
            end
            ST_HEADER: begin
                o_in_ready = i_sts.out_free;
                if (accept) begin
                    o_cmd.store_hdr   = 1'b1;
                    o_cmd.flush_start = i_sts.hdr_done;
                    o_cmd.emit_drop   = !i_sts.hdr_done && i_in_eop;
                end
            end
            ST_PAYLOAD: begin
                o_in_ready = i_sts.out_free;
                if (accept) begin
                    o_cmd.emit_byte = 1'b1;
                    o_cmd.out_last  = i_in_eop;
                end
            end
            ST_DISCARD: begin
                o_in_ready = i_sts.out_free;
                if (accept) o_cmd.emit_drop = i_in_eop;
            end
            ST_FLUSH_RD: begin
                o_in_ready = 1'b0;
            end
            ST_FLUSH_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_hdr = 1'b1;
                    o_cmd.out_last = r_eop && i_sts.flush_last;
                end
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    `IHC_ASSERT_IMPL(a_accept_needs_room, accept, i_sts.out_free, "transfer without room")
    `IHC_ASSERT_NEXT(a_flush_follows_hdr, o_cmd.flush_start, r_state == ST_FLUSH_RD, "no flush")
    `IHC_ASSERT_IMPL(a_hold_in_flush, o_cmd.emit_hdr, !o_in_ready, "input open during flush")

endmodule

// ----- hdl/ihc_dpath.sv -----
// Header buffer, checksum accumulator, drop counter and output register.
// Depends on ihc_pkg and the block's assertion macros.
`include "ipv4_header_checksum_insert_macros.svh"

module ihc_dpath import ihc_pkg::*; #(
    parameter int MAX_HEADER_BYTES = 60
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    input  logic      i_out_stall,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(MAX_HEADER_BYTES);
    localparam int PW = $clog2(MAX_HEADER_BYTES + 1);
    localparam int CW = ((PW > HL_W) ? PW : HL_W) + 1;

    logic [7:0]      r_hdr_mem [MAX_HEADER_BYTES];
    logic [7:0]      r_rd_data;
    logic [AW-1:0]   r_rd_idx;
    logic [PW-1:0]   r_pos;
    logic [HL_W-1:0] r_hl;
    logic [15:0]     r_sum, n_sum;
    logic [7:0]      r_pend;
    logic [31:0]     r_drop, n_drop;
    logic            r_out_valid;
    t_out_item       r_out;

    logic [HL_W-1:0] hl_in;
    logic [15:0]     word;
    logic [16:0]     sum_ext;
    logic [15:0]     ck;
    logic [7:0]      hdr_byte;
    logic            load;
    logic [2:0]      loads;

    assign hl_in = HL_W'(i_in.data_byte[3:0]) << IHL_SHIFT;

    assign o_sts.hl_bad     = (hl_in < HL_W'(MIN_HDR_BYTES)) ||
                              (CW'(hl_in) > CW'(MAX_HEADER_BYTES));
    assign o_sts.hdr_done   = (CW'(r_pos) + CW'(1)) >= CW'(r_hl);
    assign o_sts.flush_last = (CW'(r_rd_idx) + CW'(1)) >= CW'(r_hl);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    // ones' complement add with end-around carry; checksum field counts as zero
    assign word    = (r_pos == PW'(CK_LO_POS)) ? 16'h0000 : {r_pend, i_in.data_byte};
    assign sum_ext = {1'b0, r_sum} + {1'b0, word};
    assign n_sum   = sum_ext[15:0] + {15'b0, sum_ext[16]};
    assign ck      = ~r_sum;

    assign n_drop = (r_drop == 32'hFFFF_FFFF) ? r_drop : r_drop + 32'd1;

    always_comb begin
        if (r_rd_idx == AW'(CK_HI_POS))      hdr_byte = ck[15:8];
        else if (r_rd_idx == AW'(CK_LO_POS)) hdr_byte = ck[7:0];
        else                                 hdr_byte = r_rd_data;
    end

    assign loads = {i_cmd.emit_byte, i_cmd.emit_drop, i_cmd.emit_hdr};
    assign load  = |loads;

    // header buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_pkt)      r_hdr_mem[0]            <= i_in.data_byte;
        else if (i_cmd.store_hdr) r_hdr_mem[r_pos[AW-1:0]] <= i_in.data_byte;
        r_rd_data <= r_hdr_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_rd_idx    <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_pkt)      r_pos <= PW'(1);
            else if (i_cmd.store_hdr) r_pos <= r_pos + PW'(1);

            if (i_cmd.flush_start)                        r_rd_idx <= '0;
            else if (i_cmd.emit_hdr && !o_sts.flush_last) r_rd_idx <= r_rd_idx + AW'(1);

            if (i_cmd.emit_drop) r_drop <= n_drop;

            if (load)              r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_pkt) begin
            r_hl   <= hl_in;
            r_sum  <= '0;
            r_pend <= i_in.data_byte;
        end else if (i_cmd.store_hdr) begin
            if (r_pos[0]) r_sum  <= n_sum;
            else          r_pend <= i_in.data_byte;
        end

        if (i_cmd.emit_drop) begin
            r_out.out_byte   <= 8'h00;
            r_out.out_last   <= 1'b1;
            r_out.dropped    <= 1'b1;
            r_out.drop_total <= n_drop;
        end else if (i_cmd.emit_hdr) begin
            r_out.out_byte   <= hdr_byte;
            r_out.out_last   <= i_cmd.out_last;
            r_out.dropped    <= 1'b0;
            r_out.drop_total <= r_drop;
        end else if (i_cmd.emit_byte) begin
            r_out.out_byte   <= i_in.data_byte;
            r_out.out_last   <= i_cmd.out_last;
            r_out.dropped    <= 1'b0;
            r_out.drop_total <= r_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `IHC_ASSERT_ALWAYS(a_one_load, $onehot0(loads), "conflicting output loads")
    `IHC_ASSERT_IMPL(a_rd_in_header, i_cmd.emit_hdr, CW'(r_rd_idx) < CW'(r_hl), "read past header")
    `IHC_ASSERT_NEXT(a_drop_monotonic, i_rst_n, r_drop >= $past(r_drop), "drop count fell")

endmodule

// ----- dv/tb_ipv4_header_checksum_insert.sv -----
`timescale 1ns / 100ps
// Self-checking bench for ipv4_header_checksum_insert. It sends random and directed packets
// under several idling patterns, and a scoreboard predicts every output transfer.
// Depends on ihc_pkg and the block RTL.
import ihc_pkg::*;

localparam int MAX_HDR_BYTES = 60;

class checksum_scoreboard;
    t_state      phase;
    logic [5:0]  hdr_pos;
    logic [5:0]  hdr_len;
    logic [7:0]  hdr_bytes [MAX_HDR_BYTES];
    logic [15:0] csum;
    logic [7:0]  word_hi;
    logic [31:0] drops;
    t_out_item   expected_out [$];
    int          results_seen;
    int          mismatches;

    function new();
        phase        = ST_FIRST;
        hdr_pos      = '0;
        hdr_len      = '0;
        csum         = '0;
        word_hi      = '0;
        drops        = '0;
        results_seen = 0;
        mismatches   = 0;
    endfunction

    function void push_result(logic [7:0] data, logic last, logic drop);
        t_out_item r;
        r.out_byte   = data;
        r.out_last   = last;
        r.dropped    = drop;
        r.drop_total = drops;
        expected_out.push_back(r);
    endfunction

    function void push_drop();
        if (drops != 32'hFFFF_FFFF)
            drops++;
        push_result(8'h00, 1'b1, 1'b1);
        phase   = ST_FIRST;
        hdr_pos = '0;
    endfunction

    // Ones' complement sum over big-endian words; the checksum word counts as zero.
    function void add_hdr_byte(int pos, logic [7:0] data);
        logic [15:0] word;
        logic [16:0] total;
        if (pos < MAX_HDR_BYTES)
            hdr_bytes[pos] = data;
        if (pos % 2 == 0) begin
            word_hi = data;
        end else begin
            word  = (pos == CK_LO_POS) ? 16'h0000 : {word_hi, data};
            total = {1'b0, csum} + {1'b0, word};
            csum  = total[15:0] + {15'h0000, total[16]};
        end
    endfunction

    function void flush_header(logic eop);
        logic [15:0] ck;
        logic [7:0]  data;
        ck = ~csum;
        for (int i = 0; i < hdr_len && i < MAX_HDR_BYTES; i++) begin
            data = hdr_bytes[i];
            if (i == CK_HI_POS)
                data = ck[15:8];
            else if (i == CK_LO_POS)
                data = ck[7:0];
            push_result(data, eop && (i + 1 == hdr_len), 1'b0);
        end
        phase   = eop ? ST_FIRST : ST_PAYLOAD;
        hdr_pos = '0;
    endfunction

    function void note_input(t_in_item it);
        logic [5:0] hl;
        logic       eop;
        eop = it.end_of_packet;
        case (phase)
            ST_FIRST: begin
                hl      = {it.data_byte[3:0], 2'b00};
                hdr_len = hl;
                csum    = '0;
                word_hi = '0;
                hdr_pos = '0;
                if (hl < MIN_HDR_BYTES || hl > MAX_HDR_BYTES) begin
                    if (eop)
                        push_drop();
                    else
                        phase = ST_DISCARD;
                end else begin
                    add_hdr_byte(0, it.data_byte);
                    hdr_pos = 6'd1;
                    if (eop)
                        push_drop();
                    else
                        phase = ST_HEADER;
                end
            end
            ST_HEADER: begin
                add_hdr_byte(hdr_pos, it.data_byte);
                hdr_pos = hdr_pos + 6'd1;
                if (hdr_pos >= hdr_len)
                    flush_header(eop);
                else if (eop)
                    push_drop();
            end
            ST_PAYLOAD: begin
                push_result(it.data_byte, eop, 1'b0);
                if (eop)
                    phase = ST_FIRST;
            end
            default: begin
                if (eop)
                    push_drop();
            end
        endcase
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch at %0t, output transfer %0d: %s", $time, results_seen, what);
    endtask

    task check_result(t_out_item got);
        t_out_item want;
        results_seen++;
        if (expected_out.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer byte=%02h last=%0b drop=%0b",
                                      got.out_byte, got.out_last, got.dropped));
            return;
        end
        want = expected_out.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.out_last !== want.out_last)
            report_mismatch($sformatf("out_last %0b, want %0b", got.out_last, want.out_last));
        if (got.dropped !== want.dropped)
            report_mismatch($sformatf("dropped %0b, want %0b", got.dropped, want.dropped));
        if (got.drop_total !== want.drop_total)
            report_mismatch($sformatf("drop_total %0d, want %0d",
                                      got.drop_total, want.drop_total));
    endtask
endclass

module tb_ipv4_header_checksum_insert;

    localparam int STALL_LIMIT    = 2000;
    localparam int HOLDOFF_CYCLES = 150;

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZERO} t_fill;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    checksum_scoreboard sb;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   bytes_sent     = 0;
    int   idle_cycles    = 0;
    int   holdoff_left   = 0;
    int   holdoff_reqs   = 0;
    int   holdoff_seen   = 0;

    ipv4_header_checksum_insert #(
        .MAX_HEADER_BYTES(MAX_HDR_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stall, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (holdoff_seen != holdoff_reqs) begin
            holdoff_seen = holdoff_reqs;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_item);
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic eop);
        t_in_item it;
        it.data_byte     = data;
        it.end_of_packet = eop;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        bytes_sent++;
    endtask

    // total_len below ihl*4 gives a truncated header; above it, a payload
    task automatic send_packet(input logic [3:0] ihl, input int total_len, input t_fill fill);
        logic [7:0] data;
        for (int i = 0; i < total_len; i++) begin
            case (fill)
                FILL_ONES: data = 8'hFF;
                FILL_ZERO: data = 8'h00;
                default:   data = 8'($urandom);
            endcase
            if (i == 0)
                data[3:0] = ihl;
            send_byte(data, i == total_len - 1);
        end
    endtask

    task automatic send_random_packet();
        int         pick;
        logic [3:0] ihl;
        pick = $urandom_range(99);
        if (pick < 80) begin
            ihl = ($urandom_range(19) == 0) ? 4'd15 : 4'($urandom_range(5, 7));
            send_packet(ihl, int'(ihl) * 4 + $urandom_range(0, 10), FILL_RANDOM);
        end else if (pick < 90) begin
            ihl = 4'($urandom_range(0, 4));
            send_packet(ihl, $urandom_range(1, 6), FILL_RANDOM);
        end else begin
            ihl = 4'($urandom_range(5, 15));
            send_packet(ihl, $urandom_range(1, int'(ihl) * 4 - 1), FILL_RANDOM);
        end
    endtask

    task automatic run_traffic(input int idle_pct, input int stall_pct, input int budget);
        int first_count;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first_count    = bytes_sent;
        while (bytes_sent - first_count < budget)
            send_random_packet();
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed packets
        send_packet(4'd5, 20, FILL_RANDOM);   // header alone is the whole packet
        send_packet(4'd15, 63, FILL_RANDOM);  // longest header
        send_packet(4'd5, 20, FILL_ONES);
        send_packet(4'd5, 24, FILL_ZERO);
        send_packet(4'd0, 1, FILL_RANDOM);    // short IHL, drop on the first byte
        send_packet(4'd4, 5, FILL_ONES);
        send_packet(4'd5, 11, FILL_RANDOM);   // packet ends inside the header
        send_packet(4'd6, 2, FILL_RANDOM);
        send_packet(4'd5, 19, FILL_ZERO);     // one byte short of the header

        run_traffic(0, 0, 20);
        run_traffic(75, 0, 20);
        run_traffic(0, 75, 20);
        run_traffic(32, 32, 20);

        // receiver holds off while a long packet keeps coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_reqs++;
        send_packet(4'd5, 40, FILL_RANDOM);

        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.expected_out.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ihc_pkg.sv
hdl/ihc_ctrl.sv
hdl/ihc_dpath.sv
hdl/ipv4_header_checksum_insert.sv
dv/tb_ipv4_header_checksum_insert.sv
